FILE: design/tx_ring_space_allocator_core_macros.svh
// Assertion macros for the transmit ring space allocator checker.
// No dependencies; included by the checker file only.
`ifndef TX_RING_SPACE_ALLOCATOR_CORE_MACROS_SVH
`define TX_RING_SPACE_ALLOCATOR_CORE_MACROS_SVH

// Property checked at every edge outside reset.
`define TRSA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// Property checked at every edge, reset included.
`define TRSA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: property failed");

`endif

FILE: design/trsa_pkg.sv
// Types and constants shared by the transmit ring space allocator.
// No dependencies; compiled first.
package trsa_pkg;

  localparam int ACTION_W  = 2;
  localparam int PKT_W     = 11;
  localparam int SHIFT_W   = 4;
  localparam int OFF_W     = 14;
  localparam int CNT_W     = 10;
  localparam int SUM_W     = OFF_W + 1;
  localparam int OUT_OFF_W = 13;
  localparam int OUT_CNT_W = 9;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [OFF_W-1:0]   RING_BYTES_RST = 14'd2048;
  localparam logic [SHIFT_W-1:0] BUF_SHIFT_RST  = 4'd5;
  localparam logic [SHIFT_W-1:0] SHIFT_MIN      = 4'd5;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX      = 4'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SEND  = 2'd0,
    ACT_DONE  = 2'd1,
    ACT_RESET = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    REG_RING_BYTES = 1'b0,
    REG_BUF_SHIFT  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [CNT_W-1:0]   total;
    logic [OFF_W-1:0]   rsz;
  } geom_t;

  typedef struct packed {
    logic [OFF_W-1:0] wr_off;
    logic [OFF_W-1:0] rd_off;
    logic [CNT_W-1:0] free;
  } ring_state_t;

  typedef struct packed {
    logic                 accepted;
    logic [OUT_OFF_W-1:0] desc_offset;
    logic [OUT_OFF_W-1:0] next_offset;
    logic [OUT_CNT_W-1:0] bufs_left;
  } result_t;

  typedef struct packed {
    logic apply;
    logic reinit;
  } step_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [OFF_W-1:0] data;
  } tbl_wr_t;

endpackage

FILE: design/trsa_req_if.sv
// Request and result channel interfaces of the ring space allocator.
// Depends on trsa_pkg for field widths.
interface trsa_req_if;
  import trsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PKT_W-1:0]    pkt_bytes;

  modport source (output valid, output action, output pkt_bytes, input ready);
  modport sink (input valid, input action, input pkt_bytes, output ready);
endinterface

interface trsa_res_if;
  import trsa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [OUT_OFF_W-1:0] desc_offset;
  logic [OUT_OFF_W-1:0] next_offset;
  logic [OUT_CNT_W-1:0] bufs_left;

  modport source (output valid, output accepted, output desc_offset,
                  output next_offset, output bufs_left, input ready);
  modport sink (input valid, input accepted, input desc_offset,
                input next_offset, input bufs_left, output ready);
endinterface

FILE: design/trsa_regs.sv
// APB configuration registers and derived ring geometry.
// Depends on trsa_pkg.
module trsa_regs #(
  parameter int RAM_BYTES   = 8192,
  parameter int MAX_BUFFERS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [trsa_pkg::APB_AW-1:0] paddr,
  input  logic [trsa_pkg::APB_DW-1:0] pwdata,
  output logic [trsa_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output trsa_pkg::geom_t            geom,
  output logic                       reinit
);
  import trsa_pkg::*;

  localparam int OFF_MAX = (1 << OFF_W) - 1;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam logic [OFF_W-1:0] RAM_CAP =
    OFF_W'((RAM_BYTES > OFF_MAX) ? OFF_MAX : RAM_BYTES);
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_BUFFERS > CNT_MAX) ? CNT_MAX : MAX_BUFFERS);

  logic [OFF_W-1:0]   ring_bytes;
  logic [SHIFT_W-1:0] buf_shift;
  logic               wr_hit;
  reg_idx_t           idx;
  logic [SHIFT_W-1:0] sh;
  logic [OFF_W-1:0]   ring_cap;
  logic [CNT_W-1:0]   nbufs;
  logic [CNT_W-1:0]   total;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_hit = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_bytes <= RING_BYTES_RST;
      buf_shift  <= BUF_SHIFT_RST;
      reinit     <= 1'b1;
    end else begin
      reinit <= wr_hit;
      if (wr_hit) begin
        case (idx)
          REG_RING_BYTES: ring_bytes <= pwdata[OFF_W-1:0];
          REG_BUF_SHIFT:  buf_shift  <= pwdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_RING_BYTES: prdata = APB_DW'(ring_bytes);
      REG_BUF_SHIFT:  prdata = APB_DW'(buf_shift);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (buf_shift inside {[SHIFT_MIN:SHIFT_MAX]}) sh = buf_shift;
    else if (buf_shift < SHIFT_MIN) sh = SHIFT_MIN;
    else sh = SHIFT_MAX;
  end

  assign ring_cap = (ring_bytes > RAM_CAP) ? RAM_CAP : ring_bytes;
  assign nbufs    = CNT_W'(ring_cap >> sh);
  assign total    = (nbufs > CNT_CAP) ? CNT_CAP : nbufs;

  assign geom.shift = sh;
  assign geom.total = total;
  assign geom.rsz   = OFF_W'(total) << sh;

endmodule

FILE: design/trsa_next_ram.sv
// Per-buffer next-offset table: one write port, one registered read port.
// A read of the address being written returns the new data.
module trsa_next_ram #(
  parameter int AW = 8,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) rd_data <= wr_data;
    else rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/trsa_engine.sv
// Event logic: space check, buffer rounding, wrap, free and reset.
// Depends on trsa_pkg; purely combinational.
module trsa_engine #(
  parameter int HEADER_BYTES = 7,
  parameter int AW           = 8
) (
  input  trsa_pkg::geom_t               geom,
  input  trsa_pkg::ring_state_t         st,
  input  trsa_pkg::step_ctrl_t          ctrl,
  input  logic [trsa_pkg::ACTION_W-1:0] action,
  input  logic [trsa_pkg::PKT_W-1:0]    pkt_bytes,
  input  logic [trsa_pkg::OFF_W-1:0]    head_next,
  output trsa_pkg::ring_state_t         st_next,
  output trsa_pkg::result_t             result,
  output trsa_pkg::tbl_wr_t             tbl_wr,
  output logic [AW-1:0]                 wr_slot,
  output logic [AW-1:0]                 rd_slot
);
  import trsa_pkg::*;

  localparam int RND_W = PKT_W + 1;

  action_t          act;
  logic             same;
  logic             full;
  logic             empty;
  logic [SUM_W-1:0] avail;
  logic [RND_W-1:0] pkt_h;
  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] bufs;
  logic [RND_W-1:0] span;
  logic [SUM_W-1:0] wrap0;
  logic [SUM_W-1:0] wrap1;
  logic [OFF_W-1:0] send_next;
  logic             fits;
  logic [CNT_W-1:0] free_sub;
  logic [OFF_W-1:0] done_next;
  logic [SUM_W-1:0] span_done;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] free_add;
  ring_state_t      stay;
  ring_state_t      cleared;
  logic [OFF_W-1:0] d_off;
  logic [OFF_W-1:0] n_off;
  logic             acc;

  assign act   = action_t'(action);
  assign same  = (st.wr_off == st.rd_off);
  assign full  = same && (st.free != geom.total);
  assign empty = same && (st.free == geom.total);

  assign avail = (st.wr_off >= st.rd_off)
               ? SUM_W'(st.rd_off) + SUM_W'(geom.rsz) - SUM_W'(st.wr_off)
               : SUM_W'(st.rd_off) - SUM_W'(st.wr_off);

  assign pkt_h = RND_W'(pkt_bytes) + RND_W'(HEADER_BYTES);
  assign rnd   = pkt_h + ((RND_W'(1) << geom.shift) - RND_W'(1));
  assign bufs  = rnd >> geom.shift;
  assign span  = bufs << geom.shift;
  assign fits  = !full && (SUM_W'(pkt_h) <= avail);

  assign wrap0     = SUM_W'(st.wr_off) + SUM_W'(span);
  assign wrap1     = (wrap0 >= SUM_W'(geom.rsz)) ? wrap0 - SUM_W'(geom.rsz) : wrap0;
  assign send_next = (wrap1 >= SUM_W'(geom.rsz)) ? '0 : wrap1[OFF_W-1:0];
  assign free_sub  = (RND_W'(st.free) < bufs) ? '0 : st.free - bufs[CNT_W-1:0];

  assign done_next = (head_next >= geom.rsz) ? '0 : head_next;
  assign span_done = (done_next > st.rd_off)
                   ? SUM_W'(done_next) - SUM_W'(st.rd_off)
                   : SUM_W'(geom.rsz) - SUM_W'(st.rd_off) + SUM_W'(done_next);
  assign sum       = SUM_W'(st.free) + (span_done >> geom.shift);
  assign free_add  = (sum > SUM_W'(geom.total)) ? geom.total : sum[CNT_W-1:0];

  always_comb begin
    cleared.wr_off = '0;
    cleared.rd_off = '0;
    cleared.free   = geom.total;
  end

  always_comb begin
    stay      = st;
    d_off     = st.wr_off;
    n_off     = st.wr_off;
    acc       = 1'b0;
    tbl_wr.en = 1'b0;
    case (act)
      ACT_SEND: begin
        if (fits) begin
          stay.wr_off = send_next;
          stay.free   = free_sub;
          n_off       = send_next;
          acc         = 1'b1;
          tbl_wr.en   = ctrl.apply;
        end
      end
      ACT_DONE: begin
        d_off = st.rd_off;
        n_off = st.rd_off;
        if (!empty) begin
          stay.rd_off = done_next;
          stay.free   = free_add;
          n_off       = done_next;
          acc         = 1'b1;
        end
      end
      ACT_RESET: begin
        stay  = cleared;
        d_off = '0;
        n_off = '0;
        acc   = 1'b1;
      end
      default: ;
    endcase
  end

  assign tbl_wr.data = send_next;

  assign result.accepted    = acc;
  assign result.desc_offset = d_off[OUT_OFF_W-1:0];
  assign result.next_offset = n_off[OUT_OFF_W-1:0];
  assign result.bufs_left   = stay.free[OUT_CNT_W-1:0];

  assign st_next = ctrl.reinit ? cleared : (ctrl.apply ? stay : st);
  assign wr_slot = AW'(st.wr_off >> geom.shift);
  assign rd_slot = AW'(st_next.rd_off >> geom.shift);

endmodule

FILE: design/tx_ring_space_allocator_core.sv
// Transmit ring space allocator, top level.
// A request is registered in the a stage (a_action, a_pkt) and its result in the b stage (b_res).
// Throughput: one request per cycle unless the result stalls or a clear is pending;
// the next-table head is prefetched each cycle, so back-to-back done events do not stall.
// Reset (synchronous, rst high) and any register write empty the ring: the
// registered reinit flag sets the offsets to zero and the free count to the ring total.
module tx_ring_space_allocator_core #(
  parameter int HEADER_BYTES = 7,
  parameter int RAM_BYTES    = 8192,
  parameter int MAX_BUFFERS  = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  trsa_req_if.sink                    req,
  trsa_res_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trsa_pkg::APB_AW-1:0] paddr,
  input  logic [trsa_pkg::APB_DW-1:0] pwdata,
  output logic [trsa_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import trsa_pkg::*;

  localparam int AW = $clog2(MAX_BUFFERS);

  geom_t               geom;
  logic                reinit;
  logic                a_valid;
  logic [ACTION_W-1:0] a_action;
  logic [PKT_W-1:0]    a_pkt;
  logic                b_valid;
  result_t             b_res;
  logic                b_ready;
  logic                adv;
  ring_state_t         st;
  ring_state_t         st_next;
  result_t             result;
  tbl_wr_t             tbl_wr;
  step_ctrl_t          ctrl;
  logic [AW-1:0]       wr_slot;
  logic [AW-1:0]       rd_slot;
  logic [OFF_W-1:0]    head_next;

  trsa_regs #(
    .RAM_BYTES   (RAM_BYTES),
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom),
    .reinit  (reinit)
  );

  // a held request waits out the ring clear
  assign b_ready   = !b_valid || res.ready;
  assign adv       = a_valid && b_ready && !reinit;
  assign req.ready = !rst && (!a_valid || adv);

  assign ctrl.apply  = adv;
  assign ctrl.reinit = reinit;

  trsa_engine #(
    .HEADER_BYTES (HEADER_BYTES),
    .AW           (AW)
  ) u_engine (
    .geom      (geom),
    .st        (st),
    .ctrl      (ctrl),
    .action    (a_action),
    .pkt_bytes (a_pkt),
    .head_next (head_next),
    .st_next   (st_next),
    .result    (result),
    .tbl_wr    (tbl_wr),
    .wr_slot   (wr_slot),
    .rd_slot   (rd_slot)
  );

  trsa_next_ram #(
    .AW (AW),
    .DW (OFF_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (tbl_wr.en),
    .wr_addr (wr_slot),
    .wr_data (tbl_wr.data),
    .rd_addr (rd_slot),
    .rd_data (head_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      a_action <= req.action;
      a_pkt    <= req.pkt_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= 1'b1;
    end else if (res.ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) b_res <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

  assign res.valid       = b_valid;
  assign res.accepted    = b_res.accepted;
  assign res.desc_offset = b_res.desc_offset;
  assign res.next_offset = b_res.next_offset;
  assign res.bufs_left   = b_res.bufs_left;

endmodule

FILE: design/trsa_checker.sv
// Port-level checks for the transmit ring space allocator.
// Depends on trsa_pkg and tx_ring_space_allocator_core_macros.svh; bound to the top.
`include "tx_ring_space_allocator_core_macros.svh"

module trsa_checker #(
  parameter int MAX_BUFFERS = 256
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic                           res_accepted,
  input logic [trsa_pkg::OUT_OFF_W-1:0] res_desc_offset,
  input logic [trsa_pkg::OUT_OFF_W-1:0] res_next_offset,
  input logic [trsa_pkg::OUT_CNT_W-1:0] res_bufs_left
);
  import trsa_pkg::*;

  // stalled result holds
  `TRSA_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_accepted) && $stable(res_desc_offset) && $stable(res_next_offset) && $stable(res_bufs_left))

  // a refused request leaves the offset where it was
  `TRSA_ASSERT(a_refused_same, clk, rst, res_valid && !res_accepted |-> res_desc_offset == res_next_offset)

  // free count never exceeds the buffer cap
  `TRSA_ASSERT(a_bufs_cap, clk, rst, res_valid |-> 32'(res_bufs_left) <= MAX_BUFFERS)

  // no result straight after reset
  `TRSA_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !res_valid)

endmodule

bind tx_ring_space_allocator_core trsa_checker #(
  .MAX_BUFFERS (MAX_BUFFERS)
) u_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_accepted    (res.accepted),
  .res_desc_offset (res.desc_offset),
  .res_next_offset (res.next_offset),
  .res_bufs_left   (res.bufs_left)
);

FILE: test/tb_tx_ring_space_allocator_core.sv
// Testbench for tx_ring_space_allocator_core: directed and random requests over
// several ring geometries, each result checked against an in-bench ring model.
// Depends on trsa_pkg, trsa_req_if/trsa_res_if and the core RTL.
module tb_tx_ring_space_allocator_core;
  import trsa_pkg::*;

  localparam int HDR_BYTES  = 7;
  localparam int RAM_LIMIT  = 8192;
  localparam int BUF_LIMIT  = 256;
  localparam int LAT_PAUSE  = 4;
  localparam int QUIET_MAX  = 1000;
  localparam int PRINT_MAX  = 50;
  localparam int N_GEOM     = 8;

  typedef struct {
    action_t          act;
    logic [PKT_W-1:0] pkt;
  } ring_req_t;

  logic clk;
  logic rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  trsa_req_if req_ch ();
  trsa_res_if res_ch ();

  tx_ring_space_allocator_core #(
    .HEADER_BYTES(HDR_BYTES),
    .RAM_BYTES   (RAM_LIMIT),
    .MAX_BUFFERS (BUF_LIMIT)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .res    (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // ring model state
  int cfg_ring_bytes;
  int cfg_buf_shift;
  int ring_wr;
  int ring_rd;
  int ring_free;
  int next_of [BUF_LIMIT];

  ring_req_t send_queue [$];
  result_t   due_results [$];

  int  items_pushed;
  int  results_seen;
  int  mismatches;
  int  quiet_cycles;
  int  sends_granted;
  int  sends_refused;
  int  frees_done;
  int  src_idle_pct;
  int  snk_idle_pct;
  bit  req_taken;

  int seg_ring  [N_GEOM];
  int seg_shift [N_GEOM];
  int seg_items [N_GEOM];

  function automatic int geo_shift();
    if (cfg_buf_shift < SHIFT_MIN) return SHIFT_MIN;
    if (cfg_buf_shift > SHIFT_MAX) return SHIFT_MAX;
    return cfg_buf_shift;
  endfunction

  function automatic int geo_total();
    int bytes;
    int n;
    bytes = (cfg_ring_bytes > RAM_LIMIT) ? RAM_LIMIT : cfg_ring_bytes;
    n = bytes >> geo_shift();
    return (n > BUF_LIMIT) ? BUF_LIMIT : n;
  endfunction

  function automatic void clear_ring();
    ring_wr   = 0;
    ring_rd   = 0;
    ring_free = geo_total();
  endfunction

  function automatic void set_ring_register(reg_idx_t idx, int value);
    if (idx == REG_RING_BYTES) cfg_ring_bytes = value & 'h3FFF;
    else cfg_buf_shift = value & 'hF;
    clear_ring();
  endfunction

  function automatic result_t predict_ring_result(action_t act, logic [PKT_W-1:0] pkt);
    int      sh;
    int      total;
    int      rsz;
    int      space;
    int      bufs;
    int      nxt;
    int      bytes;
    bit      empty;
    result_t r;
    sh    = geo_shift();
    total = geo_total();
    rsz   = total << sh;
    empty = (ring_wr == ring_rd) && (ring_free == total);
    r.accepted    = 1'b0;
    r.desc_offset = ring_wr[OUT_OFF_W-1:0];
    r.next_offset = ring_wr[OUT_OFF_W-1:0];
    case (act)
      ACT_SEND: begin
        if (ring_wr >= ring_rd) space = ring_rd + rsz - ring_wr - HDR_BYTES;
        else space = ring_rd - ring_wr - HDR_BYTES;
        // equal offsets with buffers in use: full, refuse
        if (!(ring_wr == ring_rd && !empty) && int'(pkt) <= space) begin
          bufs = (int'(pkt) + HDR_BYTES + (1 << sh) - 1) >> sh;
          nxt  = ring_wr + (bufs << sh);
          if (nxt >= rsz) nxt -= rsz;
          if (nxt >= rsz) nxt = 0;
          next_of[(ring_wr >> sh) % BUF_LIMIT] = nxt;
          ring_free = (bufs > ring_free) ? 0 : ring_free - bufs;
          ring_wr = nxt;
          r.next_offset = nxt[OUT_OFF_W-1:0];
          r.accepted = 1'b1;
        end
      end
      ACT_DONE: begin
        r.desc_offset = ring_rd[OUT_OFF_W-1:0];
        r.next_offset = ring_rd[OUT_OFF_W-1:0];
        if (!empty) begin
          nxt = next_of[(ring_rd >> sh) % BUF_LIMIT];
          if (nxt >= rsz) nxt = 0;
          if (nxt > ring_rd) bytes = nxt - ring_rd;
          else bytes = rsz - ring_rd + nxt;
          ring_free += bytes >> sh;
          if (ring_free > total) ring_free = total;
          ring_rd = nxt;
          r.next_offset = nxt[OUT_OFF_W-1:0];
          r.accepted = 1'b1;
        end
      end
      ACT_RESET: begin
        clear_ring();
        r.desc_offset = '0;
        r.next_offset = '0;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.bufs_left = ring_free[OUT_CNT_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(string what);
    if (mismatches < PRINT_MAX) $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic queue_item(action_t act, int pkt);
    ring_req_t it;
    it.act = act;
    it.pkt = pkt[PKT_W-1:0];
    send_queue.push_back(it);
    items_pushed++;
  endtask

  task automatic drain_and_settle();
    while (results_seen != items_pushed) @(negedge clk);
    repeat (LAT_PAUSE) @(negedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_ring_register(idx, value);
  endtask

  // runs of fill-heavy or drain-heavy traffic so the ring reaches full and empty
  task automatic queue_random(int count);
    int sh;
    int mood;
    int send_pct;
    int roll;
    int pkt;
    sh = geo_shift();
    mood = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) mood = $urandom_range(0, 2);
      send_pct = (mood == 0) ? 80 : (mood == 1) ? 25 : 55;
      case ($urandom_range(0, 3))
        0: pkt = $urandom_range(0, 63);
        1: pkt = $urandom_range(0, 2047);
        2: pkt = $urandom_range(1, 8) * (1 << sh) - HDR_BYTES + $urandom_range(0, 2) - 1;
        default: pkt = $urandom_range(0, 511);
      endcase
      if (pkt > 2047) pkt = 2047;
      roll = $urandom_range(0, 99);
      if (roll < send_pct) queue_item(ACT_SEND, pkt);
      else if (roll < 96) queue_item(ACT_DONE, pkt);
      else if (roll < 98) queue_item(ACT_RESET, pkt);
      else queue_item(ACT_NOP, pkt);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin : drive
    ring_req_t it;
    if (rst) begin
      req_ch.valid <= 1'b0;
      res_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_taken) begin
        if (send_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          it = send_queue.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.action    <= it.act;
          req_ch.pkt_bytes <= it.pkt;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // result monitor, model update and watchdog
  always @(posedge clk) begin : watch
    result_t want;
    result_t pred;
    if (rst) begin
      req_taken    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = due_results.pop_front();
          if (res_ch.accepted !== want.accepted)
            note_mismatch($sformatf("accepted got %b want %b", res_ch.accepted, want.accepted));
          if (res_ch.desc_offset !== want.desc_offset)
            note_mismatch($sformatf("desc_offset got %0d want %0d",
                                    res_ch.desc_offset, want.desc_offset));
          if (res_ch.next_offset !== want.next_offset)
            note_mismatch($sformatf("next_offset got %0d want %0d",
                                    res_ch.next_offset, want.next_offset));
          if (res_ch.bufs_left !== want.bufs_left)
            note_mismatch($sformatf("bufs_left got %0d want %0d",
                                    res_ch.bufs_left, want.bufs_left));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pred = predict_ring_result(action_t'(req_ch.action), req_ch.pkt_bytes);
        due_results.push_back(pred);
        if (action_t'(req_ch.action) == ACT_SEND) begin
          if (pred.accepted) sends_granted++;
          else sends_refused++;
        end else if (action_t'(req_ch.action) == ACT_DONE && pred.accepted) begin
          frees_done++;
        end
      end
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("watchdog: no request or result moved for %0d cycles", QUIET_MAX);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_NOP;
    req_ch.pkt_bytes = '0;
    res_ch.ready     = 1'b0;
    items_pushed     = 0;
    results_seen     = 0;
    mismatches       = 0;
    sends_granted    = 0;
    sends_refused    = 0;
    frees_done       = 0;
    src_idle_pct     = 34;
    snk_idle_pct     = 61;
    cfg_ring_bytes   = RING_BYTES_RST;
    cfg_buf_shift    = BUF_SHIFT_RST;
    clear_ring();
    // clamped, minimal, all-ones/all-zeros and uneven geometries
    seg_ring  = '{8192, 256, 16383, 1000, 0, 3000, 8191, 2048};
    seg_shift = '{5, 8, 0, 6, 5, 7, 15, 5};
    seg_items = '{300, 200, 250, 250, 20, 250, 250, 350};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (LAT_PAUSE) @(negedge clk);
    @(posedge clk);

    // reset geometry: 64 buffers of 32 bytes
    queue_item(ACT_SEND, 0);
    queue_item(ACT_SEND, 2047);
    queue_item(ACT_DONE, 0);
    queue_item(ACT_DONE, 2047);
    queue_item(ACT_NOP, 2047);
    queue_item(ACT_SEND, 2041);
    queue_item(ACT_SEND, 0);
    queue_item(ACT_DONE, 0);
    queue_item(ACT_SEND, 2042);
    queue_item(ACT_SEND, 25);
    queue_item(ACT_SEND, 26);
    queue_item(ACT_SEND, 1000);
    queue_item(ACT_SEND, 1000);
    queue_item(ACT_DONE, 0);
    queue_item(ACT_RESET, 1365);
    queue_item(ACT_DONE, 682);
    queue_item(ACT_SEND, 2041);
    queue_item(ACT_RESET, 0);
    queue_item(ACT_NOP, 0);
    queue_item(ACT_SEND, 1024);
    queue_item(ACT_SEND, 1024);
    queue_item(ACT_DONE, 0);
    queue_item(ACT_SEND, 900);
    queue_item(ACT_DONE, 0);
    queue_item(ACT_DONE, 0);

    for (int s = 0; s < N_GEOM; s++) begin
      drain_and_settle();
      if (s < 2) begin
        src_idle_pct = 34;
        snk_idle_pct = 61;
      end else if (s < 5) begin
        src_idle_pct = 61;
        snk_idle_pct = 34;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      apb_write(REG_RING_BYTES, seg_ring[s]);
      apb_write(REG_BUF_SHIFT, seg_shift[s]);
      @(posedge clk);
      queue_random(seg_items[s]);
    end

    drain_and_settle();
    repeat (LAT_PAUSE * 2) @(negedge clk);
    if (due_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("ran %0d requests over %0d ring geometries: %0d sends granted, %0d refused",
             items_pushed, N_GEOM + 1, sends_granted, sends_refused);
    $display("%0d packets freed, %0d mismatches", frees_done, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
